[rtl/client_health_rate_limiter_unit_macros.svh]
// ============================================================================
// client_health_rate_limiter_unit_macros.svh
// Assertion macros shared by the rate limiter RTL.
// ============================================================================
`ifndef CLIENT_HEALTH_RATE_LIMITER_UNIT_MACROS_SVH
`define CLIENT_HEALTH_RATE_LIMITER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHRL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define CHRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

[rtl/chrl_pkg.sv]
// ============================================================================
// chrl_pkg
// Types and constants of the client health rate limiter.
// ============================================================================
package chrl_pkg;

    // Field widths
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned TIME_W   = 48;
    localparam int unsigned HEALTH_W = 16;
    localparam int unsigned MIN_W    = 20;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    // Full health, 100.0 in signed 8.8 fixed point
    localparam logic signed [HEALTH_W-1:0] HEALTH_MAX = 16'sd25600;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REWARD       = 2'd2;

    // Configuration reset values
    localparam logic [MIN_W-1:0]  MIN_INTERVAL_RST = 20'd1000;
    localparam logic [STEP_W-1:0] PENALTY_RST      = 15'd2560;
    localparam logic [STEP_W-1:0] REWARD_RST       = 15'd256;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

[rtl/chrl_if.sv]
// ============================================================================
// chrl_if
// Valid/ready channel interfaces: requests, results and configuration writes.
// ============================================================================

// Request channel: client slot and current time
interface chrl_req_if;
    logic                            valid;
    logic                            ready;
    logic [chrl_pkg::INDEX_W-1:0]    client_index;
    logic [chrl_pkg::TIME_W-1:0]     now_ms;

    modport source (output valid, output client_index, output now_ms, input ready);
    modport sink   (input valid, input client_index, input now_ms, output ready);
endinterface

// Result channel: decision and health after the request
interface chrl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic signed [chrl_pkg::HEALTH_W-1:0] health_after;

    modport source (output valid, output accepted, output health_after, input ready);
    modport sink   (input valid, input accepted, input health_after, output ready);
endinterface

// Configuration write channel
interface chrl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [chrl_pkg::CFG_IDX_W-1:0]    index;
    logic [chrl_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/client_health_rate_limiter_unit.sv]
// ============================================================================
// client_health_rate_limiter_unit
// Per-client request rate limiter with a health score per slot.
// ============================================================================
// Usage: each transfer on i_req names a client slot and the current time in
// milliseconds; exactly one transfer on o_rsp follows, saying whether the
// request is accepted and giving the slot's health (signed 8.8) afterwards.
// Configuration writes on i_cfg are always taken (index 0 minimum interval,
// 1 penalty, 2 reward); other indexes are ignored.
// Health and last-accepted time live in two single-port-write memories with
// a registered read. The request transfer issues the read; in the EXEC state
// that follows, once the result register is free, the entry is modified,
// written back and the result register loaded. The block takes no new
// request until this read-modify-write of the tables is done.
// After reset a clearing pass writes every slot back to full health and
// never-seen time; i_req is not ready until it ends.
// When the receiver stalls, the result waits in the output register; one
// further request may be taken and is held before write-back until the
// result register frees.
// ============================================================================
`include "client_health_rate_limiter_unit_macros.svh"

module client_health_rate_limiter_unit #(
    parameter int unsigned NUM_CLIENTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chrl_req_if.sink   i_req,
    chrl_rsp_if.source o_rsp,
    chrl_cfg_if.sink   i_cfg
);

    localparam int unsigned AW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int unsigned IW = (AW > chrl_pkg::INDEX_W) ? AW : chrl_pkg::INDEX_W;
    localparam int unsigned HW = chrl_pkg::HEALTH_W;
    localparam int unsigned TW = chrl_pkg::TIME_W;

    // Configuration registers
    logic [chrl_pkg::MIN_W-1:0]  r_min_interval;
    logic [chrl_pkg::STEP_W-1:0] r_penalty;
    logic [chrl_pkg::STEP_W-1:0] r_reward;

    // Control
    chrl_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr;

    // Request held during execution
    logic [AW-1:0]    r_addr;
    logic             r_in_range;
    logic [TW-1:0]    r_now;

    // Tables and their registered read data
    logic signed [HW-1:0] r_health_mem [NUM_CLIENTS];
    logic [TW-1:0]        r_time_mem   [NUM_CLIENTS];
    logic signed [HW-1:0] r_rd_health;
    logic [TW-1:0]        r_rd_time;

    // Result register
    logic                 r_out_valid;
    logic                 r_out_accepted;
    logic signed [HW-1:0] r_out_health;

    // Combinational signals
    logic                 w_req_xfer;
    logic                 w_load;
    logic                 w_clr_wr;
    logic [IW-1:0]        w_idx_ext;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_idx_in_range;
    logic                 w_blocked;
    logic                 w_first;
    logic signed [TW:0]   w_gap;
    logic signed [TW:0]   w_min_ext;
    logic                 w_fast;
    logic signed [HW:0]   w_h_ext;
    logic signed [HW:0]   w_h_sub;
    logic signed [HW:0]   w_h_add;
    logic signed [HW:0]   w_h_calc;
    logic signed [HW-1:0] w_h_new;
    logic                 w_accept;
    logic                 w_h_wr;
    logic                 w_t_wr;
    logic [AW-1:0]        w_wr_addr;
    logic signed [HW-1:0] w_h_wdata;
    logic [TW-1:0]        w_t_wdata;

    // Handshakes
    assign i_req.ready = (r_state == chrl_pkg::ST_IDLE);
    assign w_req_xfer  = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.accepted     = r_out_accepted;
    assign o_rsp.health_after = r_out_health;

    // Slot decode of the incoming request
    assign w_idx_ext      = IW'(i_req.client_index);
    assign w_rd_addr      = w_idx_ext[AW-1:0];
    assign w_idx_in_range = (32'(i_req.client_index) < NUM_CLIENTS);

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= chrl_pkg::MIN_INTERVAL_RST;
            r_penalty      <= chrl_pkg::PENALTY_RST;
            r_reward       <= chrl_pkg::REWARD_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                chrl_pkg::CFG_MIN_INTERVAL: r_min_interval <= i_cfg.data[chrl_pkg::MIN_W-1:0];
                chrl_pkg::CFG_PENALTY:      r_penalty      <= i_cfg.data[chrl_pkg::STEP_W-1:0];
                chrl_pkg::CFG_REWARD:       r_reward       <= i_cfg.data[chrl_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Health update from the entry read at the request transfer
    always_comb begin
        w_blocked = !r_in_range || (r_rd_health <= 0);
        w_first   = (r_rd_time == '0);
        w_gap     = signed'({1'b0, r_now}) - signed'({1'b0, r_rd_time});
        w_min_ext = signed'((TW+1)'(r_min_interval));
        w_fast    = (w_gap < w_min_ext);
        w_h_ext   = (HW+1)'(r_rd_health);
        w_h_sub   = w_h_ext - signed'((HW+1)'(r_penalty));
        w_h_add   = w_h_ext + signed'((HW+1)'(r_reward));
        if (w_first) begin
            w_h_calc = w_h_ext;
        end else if (w_fast) begin
            w_h_calc = w_h_sub;
        end else if (w_h_add > (HW+1)'(chrl_pkg::HEALTH_MAX)) begin
            w_h_calc = (HW+1)'(chrl_pkg::HEALTH_MAX);
        end else begin
            w_h_calc = w_h_add;
        end
        w_h_new  = w_h_calc[HW-1:0];
        w_accept = !w_blocked && (w_h_new > 0);
    end

    // Sequencer: clearing pass, idle and read-modify-write
    always_comb begin
        n_state  = r_state;
        w_load   = 1'b0;
        w_clr_wr = 1'b0;
        case (r_state)
            chrl_pkg::ST_CLEAR: begin
                w_clr_wr = 1'b1;
                if (r_clr_addr == AW'(NUM_CLIENTS - 1)) begin
                    n_state = chrl_pkg::ST_IDLE;
                end
            end
            chrl_pkg::ST_IDLE: begin
                if (w_req_xfer) begin
                    n_state = chrl_pkg::ST_EXEC;
                end
            end
            chrl_pkg::ST_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_load  = 1'b1;
                    n_state = chrl_pkg::ST_IDLE;
                end
            end
            default: n_state = chrl_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= chrl_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Capture of the accepted request
    always_ff @(posedge i_clk) begin
        if (w_req_xfer) begin
            r_addr     <= w_rd_addr;
            r_in_range <= w_idx_in_range;
            r_now      <= i_req.now_ms;
        end
    end

    // Table write port: clearing pass or write-back
    always_comb begin
        w_wr_addr = w_clr_wr ? r_clr_addr : r_addr;
        w_h_wdata = w_clr_wr ? chrl_pkg::HEALTH_MAX : w_h_new;
        w_t_wdata = w_clr_wr ? '0 : r_now;
        w_h_wr    = w_clr_wr || (w_load && !w_blocked);
        w_t_wr    = w_clr_wr || (w_load && w_accept);
    end

    // Health memory
    always_ff @(posedge i_clk) begin
        if (w_h_wr) begin
            r_health_mem[w_wr_addr] <= w_h_wdata;
        end
        if (w_req_xfer) begin
            r_rd_health <= r_health_mem[w_rd_addr];
        end
    end

    // Last-accepted time memory
    always_ff @(posedge i_clk) begin
        if (w_t_wr) begin
            r_time_mem[w_wr_addr] <= w_t_wdata;
        end
        if (w_req_xfer) begin
            r_rd_time <= r_time_mem[w_rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_accepted <= w_accept;
            if (!r_in_range) begin
                r_out_health <= '0;
            end else if (w_blocked) begin
                r_out_health <= r_rd_health;
            end else begin
                r_out_health <= w_h_new;
            end
        end
    end

    // Assertions
    `CHRL_ASSERT_NEXT(a_req_to_exec, i_clk, i_rst_n, w_req_xfer, r_state == chrl_pkg::ST_EXEC)
    `CHRL_ASSERT_SAME(a_no_wr_idle, i_clk, i_rst_n, r_state == chrl_pkg::ST_IDLE, !w_h_wr && !w_t_wr)
    `CHRL_ASSERT_SAME(a_accept_pos, i_clk, i_rst_n, r_out_valid && r_out_accepted, r_out_health > 0)
    `CHRL_ASSERT_NEXT(a_load_result, i_clk, i_rst_n, w_load, r_out_valid && r_state == chrl_pkg::ST_IDLE)

endmodule

[verif/chrl_health_monitor.sv]
// ============================================================================
// chrl_health_monitor
// Watches the request, result and configuration channels of the rate
// limiter, keeps its own copy of the health and last-seen tables, works out
// the decision for every request transfer and compares each result transfer
// against the oldest decision still waiting.
// ============================================================================
module chrl_health_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    chrl_req_if  i_req,
    chrl_rsp_if  i_rsp,
    chrl_cfg_if  i_cfg,
    output int   o_failures,
    output int   o_waiting
);

    localparam int unsigned SLOTS      = 64;
    localparam int unsigned MAX_REPORT = 10;

    // One decision as the result channel carries it.
    typedef struct packed {
        logic                                 accepted;
        logic signed [chrl_pkg::HEALTH_W-1:0] health;
    } t_verdict;

    // Shadow copy of the block's tables and registers.
    logic signed [chrl_pkg::HEALTH_W-1:0] health_mem [SLOTS];
    logic [chrl_pkg::TIME_W-1:0]          seen_mem   [SLOTS];
    logic [chrl_pkg::MIN_W-1:0]           min_gap_ms;
    logic [chrl_pkg::STEP_W-1:0]          penalty;
    logic [chrl_pkg::STEP_W-1:0]          reward;

    // Decisions waiting for their result transfer, oldest first.
    t_verdict verdict_fifo [$];
    int       mismatches = 0;

    // Counts a failure; only the first few are printed in full.
    task automatic flag(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORT) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // Decides one request and updates the shadow tables as the block would.
    function automatic t_verdict judge_request(input logic [chrl_pkg::INDEX_W-1:0] slot,
                                               input logic [chrl_pkg::TIME_W-1:0]  now);
        t_verdict           v;
        logic signed [31:0] level;
        logic signed [31:0] pen_s;
        logic signed [31:0] rew_s;
        logic signed [63:0] span;
        logic signed [63:0] floor_ms;

        level    = health_mem[slot];
        pen_s    = {17'd0, penalty};
        rew_s    = {17'd0, reward};
        floor_ms = {44'd0, min_gap_ms};

        // A slot at or below zero stays blocked and keeps its entries.
        if (level <= 0) begin
            v.accepted = 1'b0;
            v.health   = health_mem[slot];
            return v;
        end

        // A stored time of zero marks a first request: health is left alone.
        if (seen_mem[slot] != '0) begin
            span = $signed({16'd0, now}) - $signed({16'd0, seen_mem[slot]});
            if (span < floor_ms) begin
                level = level - pen_s;
            end else begin
                level = level + rew_s;
                if (level > chrl_pkg::HEALTH_MAX) begin
                    level = chrl_pkg::HEALTH_MAX;
                end
            end
        end

        health_mem[slot] = level[chrl_pkg::HEALTH_W-1:0];
        v.health         = level[chrl_pkg::HEALTH_W-1:0];
        if (level <= 0) begin
            v.accepted = 1'b0;
        end else begin
            v.accepted     = 1'b1;
            seen_mem[slot] = now;
        end
        return v;
    endfunction

    // Transfers are taken in the order result, request, configuration, so a
    // result never meets the decision of a request taken at the same edge.
    always @(posedge i_clk) begin : watch
        t_verdict got;
        t_verdict want;

        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                health_mem[s] = chrl_pkg::HEALTH_MAX;
                seen_mem[s]   = '0;
            end
            min_gap_ms = chrl_pkg::MIN_INTERVAL_RST;
            penalty    = chrl_pkg::PENALTY_RST;
            reward     = chrl_pkg::REWARD_RST;
            verdict_fifo.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.accepted = i_rsp.accepted;
                got.health   = i_rsp.health_after;
                if (verdict_fifo.size() == 0) begin
                    flag($sformatf("result with nothing expected: accepted=%0d health=%0d",
                                   got.accepted, got.health));
                end else begin
                    want = verdict_fifo.pop_front();
                    if (got.accepted !== want.accepted) begin
                        flag($sformatf("accepted: expected %0d, got %0d",
                                       want.accepted, got.accepted));
                    end
                    if (got.health !== want.health) begin
                        flag($sformatf("health_after: expected %0d, got %0d",
                                       want.health, got.health));
                    end
                end
            end

            if (i_req.valid && i_req.ready) begin
                verdict_fifo.push_back(judge_request(i_req.client_index, i_req.now_ms));
            end

            // Only the low bits of each register are kept; other indexes are ignored.
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    chrl_pkg::CFG_MIN_INTERVAL:
                        min_gap_ms = i_cfg.data[chrl_pkg::MIN_W-1:0];
                    chrl_pkg::CFG_PENALTY:
                        penalty    = i_cfg.data[chrl_pkg::STEP_W-1:0];
                    chrl_pkg::CFG_REWARD:
                        reward     = i_cfg.data[chrl_pkg::STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end

        o_waiting  <= verdict_fifo.size();
        o_failures <= mismatches;
    end

endmodule

[verif/client_health_rate_limiter_unit_tb.sv]
// ============================================================================
// client_health_rate_limiter_unit_tb
// Drives requests and register writes into the rate limiter with random idle
// gaps and result back-pressure, then gives the verdict from the monitor.
// ============================================================================
module client_health_rate_limiter_unit_tb;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 175;
    localparam int unsigned HOT_SLOTS   = 8;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [chrl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Testbench-side drivers of the channel inputs, known from time zero.
    logic                            req_valid = 1'b0;
    logic [chrl_pkg::INDEX_W-1:0]    req_index = '0;
    logic [chrl_pkg::TIME_W-1:0]     req_now   = '0;
    logic                            rsp_ready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [chrl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [chrl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic        steady      = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned spacing     = chrl_pkg::MIN_INTERVAL_RST;
    int unsigned cycle_count = 0;
    int          failures;
    int          waiting;

    chrl_req_if req_ch ();
    chrl_rsp_if rsp_ch ();
    chrl_cfg_if cfg_ch ();

    assign req_ch.valid        = req_valid;
    assign req_ch.client_index = req_index;
    assign req_ch.now_ms       = req_now;
    assign rsp_ch.ready        = rsp_ready;
    assign cfg_ch.valid        = cfg_valid;
    assign cfg_ch.index        = cfg_index;
    assign cfg_ch.data         = cfg_data;

    client_health_rate_limiter_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    chrl_health_monitor u_monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .i_cfg      (cfg_ch),
        .o_failures (failures),
        .o_waiting  (waiting)
    );

    // Clock generation.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** client_health_rate_limiter_unit: FAILED **");
            $finish;
        end
    end

    // Result receiver: random stalls, mostly short, held off in steady stretches.
    always @(posedge i_clk) begin
        if (steady) begin
            rsp_ready  <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                          : $urandom_range(15, 60);
            end
        end
    end

    // Idle cycles before the next request: mostly none or a few, now and then many.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offers one request and returns at the edge of its transfer; valid stays up.
    task automatic issue_request(input logic [chrl_pkg::INDEX_W-1:0] slot,
                                 input logic [chrl_pkg::TIME_W-1:0]  now,
                                 input int unsigned                  gap);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_index <= slot;
        req_now   <= now;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Holds requests back until every result has been taken.
    task automatic settle();
        req_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    // One register write transfer; valid is lowered by the caller.
    task automatic write_register(input logic [chrl_pkg::CFG_IDX_W-1:0]  idx,
                                  input logic [chrl_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // New settings while the block is idle; spare high bits carry random junk.
    task automatic load_settings(input int unsigned min_ms,
                                 input int unsigned pen,
                                 input int unsigned rew);
        logic [chrl_pkg::CFG_DATA_W-1:0] junk;
        settle();
        junk = (chrl_pkg::CFG_DATA_W)'($urandom) & 20'hF8000;
        write_register(chrl_pkg::CFG_MIN_INTERVAL, (chrl_pkg::CFG_DATA_W)'(min_ms));
        write_register(chrl_pkg::CFG_PENALTY,
                       junk | (chrl_pkg::CFG_DATA_W)'(pen & 32'h7FFF));
        junk = (chrl_pkg::CFG_DATA_W)'($urandom) & 20'hF8000;
        write_register(chrl_pkg::CFG_REWARD,
                       junk | (chrl_pkg::CFG_DATA_W)'(rew & 32'h7FFF));
        write_register(CFG_UNUSED, (chrl_pkg::CFG_DATA_W)'($urandom));
        cfg_valid <= 1'b0;
        spacing = min_ms;
    endtask

    initial begin : stimulus
        logic [chrl_pkg::TIME_W-1:0]  clock_of [64];
        logic [chrl_pkg::INDEX_W-1:0] hot [HOT_SLOTS];
        logic [chrl_pkg::INDEX_W-1:0] slot;
        int unsigned                  roll;

        for (int s = 0; s < 64; s++) begin
            clock_of[s] = (chrl_pkg::TIME_W)'($urandom_range(1, 100000));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: first request, fast, spaced, time going backwards,
        // a request at time zero, the largest time and a gap of exactly the interval.
        issue_request(6'd0, 48'd5, pick_gap());
        issue_request(6'd0, 48'd10, pick_gap());
        issue_request(6'd0, 48'd2000, pick_gap());
        issue_request(6'd0, 48'd1500, pick_gap());
        issue_request(6'd1, 48'd0, pick_gap());
        issue_request(6'd1, 48'd3, pick_gap());
        issue_request(6'd1, 48'd4, pick_gap());
        issue_request(6'd63, 48'hFFFF_FFFF_FFFF, pick_gap());
        issue_request(6'd63, 48'hFFFF_FFFF_FFFF, pick_gap());
        issue_request(6'd62, 48'd1, pick_gap());
        issue_request(6'd62, 48'd1001, pick_gap());

        // Largest registers: a fast request drives health negative, then the
        // slot is blocked; a huge gap saturates the reward.
        load_settings(20'hFFFFF, 15'h7FFF, 15'h7FFF);
        issue_request(6'd3, 48'd1, pick_gap());
        issue_request(6'd3, 48'd2, pick_gap());
        issue_request(6'd3, 48'd3, pick_gap());
        issue_request(6'd4, 48'd1, pick_gap());
        issue_request(6'd4, 48'hFFFF_FFFF_FFFF, pick_gap());
        issue_request(6'd5, 48'd10, pick_gap());
        issue_request(6'd5, 48'd5, pick_gap());

        // All registers zero: a zero gap is not too fast, a negative one is.
        load_settings(0, 0, 0);
        issue_request(6'd6, 48'd7, pick_gap());
        issue_request(6'd6, 48'd7, pick_gap());
        issue_request(6'd6, 48'd3, pick_gap());

        // Random phases; the slot-killing extreme setting comes last.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: load_settings(0, 0, 0);
                5: load_settings(20'hFFFFF, $urandom_range(0, 32767), 15'h7FFF);
                default: load_settings($urandom_range(50, 3000), $urandom_range(0, 4000),
                                       $urandom_range(0, 4000));
            endcase
            steady <= (phase == 3);
            for (int k = 0; k < HOT_SLOTS; k++) begin
                hot[k] = (chrl_pkg::INDEX_W)'($urandom_range(0, 63));
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through, let the block drain completely.
                if (n == PHASE_ITEMS / 2) begin
                    settle();
                end
                slot = ($urandom_range(0, 99) < 80)
                     ? hot[$urandom_range(0, HOT_SLOTS - 1)]
                     : (chrl_pkg::INDEX_W)'($urandom_range(0, 63));
                // Mostly well-spaced or slightly fast times, some noise.
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    clock_of[slot] += (chrl_pkg::TIME_W)'(spacing
                                      + $urandom_range(0, spacing + 10));
                end else if (roll < 85) begin
                    clock_of[slot] += (chrl_pkg::TIME_W)'($urandom_range(0, spacing));
                end else if (roll < 92) begin
                    clock_of[slot] -= (chrl_pkg::TIME_W)'($urandom_range(1, 5000));
                end else if (roll < 97) begin
                    clock_of[slot] = {16'($urandom), 32'($urandom)};
                end else begin
                    clock_of[slot] = '0;
                end
                issue_request(slot, clock_of[slot], pick_gap());
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (failures == 0 && waiting == 0) begin
            $display("** client_health_rate_limiter_unit: PASSED **");
        end else begin
            $display("** client_health_rate_limiter_unit: FAILED **");
        end
        $finish;
    end

endmodule

[client_health_rate_limiter_unit.f]
+incdir+rtl
rtl/chrl_pkg.sv
rtl/chrl_if.sv
rtl/client_health_rate_limiter_unit.sv
verif/chrl_health_monitor.sv
verif/client_health_rate_limiter_unit_tb.sv
